### src/median_of_sample_set_defines.svh
// Assertion macros for the median_of_sample_set checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef MEDIAN_OF_SAMPLE_SET_DEFINES_SVH
`define MEDIAN_OF_SAMPLE_SET_DEFINES_SVH

// Same-cycle implication.
`define MOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mos_pkg.sv
// Shared constants and types of the median_of_sample_set block.
// Depends on nothing.
package mos_pkg;

    localparam int MAX_SAMPLES   = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int MEDIAN_W      = SAMPLE_BITS + 1;
    localparam int COUNT_FIELD_W = 7;
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
    localparam int SHIFT_W       = (MAX_SAMPLES > 2) ? $clog2((MAX_SAMPLES + 1) / 2) : 1;
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_SAMPLES);
    localparam logic [COUNT_FIELD_W-1:0] COUNT_FULL_FIELD = COUNT_FIELD_W'(MAX_SAMPLES);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } mos_cell_ctl_t;

endpackage

### src/mos_if.sv
// Sample and result channel interfaces of median_of_sample_set.
// Depends on mos_pkg.
interface mos_sample_if;
    logic             valid;
    logic             ready;
    mos_pkg::sample_t sample;
    logic             last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface mos_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mos_pkg::MEDIAN_W-1:0]     median_twice;
    logic        [mos_pkg::COUNT_FIELD_W-1:0] sample_count;
    logic                                    overflow;

    modport source (output valid, output median_twice, output sample_count,
                    output overflow, input ready);
    modport sink (input valid, input median_twice, input sample_count,
                  input overflow, output ready);
endinterface

### src/mos_cell.sv
// One insertion-sort cell: holds one sample, inserts or shifts toward cell zero.
// Depends on mos_pkg.
module mos_cell (
    input  logic                  clk,
    input  mos_pkg::mos_cell_ctl_t ctl,
    input  mos_pkg::sample_t      sample,
    input  logic                  occ,
    input  logic                  lower_occ,
    input  logic                  lower_gt,
    input  mos_pkg::sample_t      lower_val,
    input  mos_pkg::sample_t      upper_val,
    output mos_pkg::sample_t      val,
    output logic                  gt
);

    mos_pkg::sample_t val_reg;
    mos_pkg::sample_t val_next;

    assign gt  = occ && (val_reg > sample);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert)
        begin
            if (lower_gt)
            begin
                val_next = lower_val;
            end
            else if (gt || (!occ && lower_occ))
            begin
                val_next = sample;
            end
        end
        else if (ctl.shift)
        begin
            val_next = upper_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### src/mos_chain.sv
// Row of sorting cells kept in ascending order; exposes the two lowest cells.
// Depends on mos_pkg and mos_cell.
module mos_chain (
    input  logic                      clk,
    input  mos_pkg::mos_cell_ctl_t    ctl,
    input  mos_pkg::sample_t          sample,
    input  logic [mos_pkg::CNT_W-1:0] count,
    output mos_pkg::sample_t          head0,
    output mos_pkg::sample_t          head1
);

    localparam int N = mos_pkg::MAX_SAMPLES;

    mos_pkg::sample_t vals [N];
    logic [N-1:0]     gts;
    logic [N-1:0]     occs;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            mos_pkg::sample_t lower_val;
            mos_pkg::sample_t upper_val;
            logic             lower_gt;
            logic             lower_occ;

            assign occs[i] = count > mos_pkg::CNT_W'(i);

            if (i == 0)
            begin : g_first
                assign lower_val = sample;
                assign lower_gt  = 1'b0;
                assign lower_occ = 1'b1;
            end
            else
            begin : g_inner
                assign lower_val = vals[i-1];
                assign lower_gt  = gts[i-1];
                assign lower_occ = occs[i-1];
            end

            if (i == N - 1)
            begin : g_top
                assign upper_val = vals[i];
            end
            else
            begin : g_mid
                assign upper_val = vals[i+1];
            end

            mos_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .sample    (sample),
                .occ       (occs[i]),
                .lower_occ (lower_occ),
                .lower_gt  (lower_gt),
                .lower_val (lower_val),
                .upper_val (upper_val),
                .val       (vals[i]),
                .gt        (gts[i])
            );
        end

        assign head0 = vals[0];
        if (N > 1)
        begin : g_head1
            assign head1 = vals[1];
        end
        else
        begin : g_head1_single
            assign head1 = vals[0];
        end
    endgenerate

endmodule

### src/median_of_sample_set.sv
// Median of a streamed set of signed samples, by insertion into a sorted cell row.
// Depends on mos_pkg, mos_if, mos_chain.
//
// Channels: samples (valid/ready, sample + last) in; result (valid/ready,
// median_twice + sample_count + overflow) out, one result per set.
// Each sample is inserted into the row of MAX_SAMPLES cells, one sample per
// cycle while samples.ready is high; samples beyond capacity are dropped and
// flag overflow. After the transfer marked last the row shifts toward cell
// zero by m = (count - 1) / 2 places (up to 31 for 64 samples), then the
// result is formed from the two lowest cells into the result register.
// samples.ready is low during that drain. The result register holds until
// taken; a stalled receiver holds the drain only at its final step, and
// samples of the next set are accepted while a result waits.
// Reset clears the count, the overflow flag, the state and result valid;
// sample contents need no reset.
module median_of_sample_set (
    input  logic                clk,
    input  logic                rst_n,
    mos_sample_if.sink          samples,
    mos_result_if.source        result
);

    typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

    state_t                           state_reg, state_next;
    logic [mos_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             dropped_reg, dropped_next;
    logic [mos_pkg::SHIFT_W-1:0]      shift_reg, shift_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [mos_pkg::MEDIAN_W-1:0] median_reg, median_next;
    logic [mos_pkg::COUNT_FIELD_W-1:0] ocount_reg, ocount_next;
    logic                             oflow_reg, oflow_next;

    mos_pkg::mos_cell_ctl_t           ctl;
    mos_pkg::sample_t                 head0;
    mos_pkg::sample_t                 head1;
    logic                             take;
    logic                             full;
    logic                             finish;
    logic [mos_pkg::CNT_W-1:0]        count_ins;
    logic [mos_pkg::CNT_W-1:0]        count_m1;
    logic signed [mos_pkg::MEDIAN_W-1:0] med_sum;

    assign samples.ready = (state_reg == ST_LOAD);
    assign take          = samples.valid && samples.ready;
    assign full          = (count_reg == mos_pkg::COUNT_FULL);
    assign ctl.insert    = take && !full;
    assign ctl.shift     = (state_reg == ST_DRAIN) && (shift_reg != '0);
    assign finish        = (state_reg == ST_DRAIN) && (shift_reg == '0)
                           && (!out_valid_reg || result.ready);
    assign count_ins     = full ? count_reg : count_reg + mos_pkg::CNT_W'(1);
    assign count_m1      = count_ins - mos_pkg::CNT_W'(1);

    assign med_sum = count_reg[0]
        ? {head0, 1'b0}
        : (mos_pkg::MEDIAN_W'(head0) + mos_pkg::MEDIAN_W'(head1));

    mos_chain u_chain (
        .clk    (clk),
        .ctl    (ctl),
        .sample (samples.sample),
        .count  (count_reg),
        .head0  (head0),
        .head1  (head1)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        ocount_next    = ocount_reg;
        oflow_next     = oflow_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (take)
                begin
                    count_next   = count_ins;
                    dropped_next = dropped_reg || full;
                    if (samples.last)
                    begin
                        shift_next = mos_pkg::SHIFT_W'(count_m1 >> 1);
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (ctl.shift)
                begin
                    shift_next = shift_reg - mos_pkg::SHIFT_W'(1);
                end
                else if (finish)
                begin
                    out_valid_next = 1'b1;
                    median_next    = med_sum;
                    ocount_next    = mos_pkg::COUNT_FIELD_W'(count_reg);
                    oflow_next     = dropped_reg;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
        ocount_reg <= ocount_next;
        oflow_reg  <= oflow_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.median_twice = median_reg;
    assign result.sample_count = ocount_reg;
    assign result.overflow     = oflow_reg;

endmodule

### src/mos_checker.sv
// Port-level checks of median_of_sample_set, attached by bind.
// Depends on mos_pkg and median_of_sample_set_defines.svh.
`include "median_of_sample_set_defines.svh"

module mos_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 in_last,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [mos_pkg::MEDIAN_W-1:0]  median_twice,
    input logic [mos_pkg::COUNT_FIELD_W-1:0]    sample_count,
    input logic                                 overflow
);

    `MOS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median_twice) && $stable(sample_count) && $stable(overflow), "result changed while stalled")
    `MOS_ASSERT_NOW(a_count_nonzero, out_valid && (mos_pkg::COUNT_FULL_FIELD != 0), sample_count != 0, "result with empty set")
    `MOS_ASSERT_NOW(a_overflow_full, out_valid && overflow, sample_count == mos_pkg::COUNT_FULL_FIELD, "overflow without full set")
    `MOS_ASSERT_NEXT(a_drain_blocks, in_valid && in_ready && in_last, !in_ready, "sample taken during drain")

endmodule

bind median_of_sample_set mos_checker u_mos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .in_last      (samples.last),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .median_twice (result.median_twice),
    .sample_count (result.sample_count),
    .overflow     (result.overflow)
);
